// ----- rtl/kcf_pkg.sv -----
// ----------------------------------------------------------------------------
// kcf_pkg
// Shared types and constants for the scancode decoder and character queue.
// ----------------------------------------------------------------------------
package kcf_pkg;

   typedef enum logic [1:0] {
      CMD_SCAN     = 2'd0,
      CMD_POP      = 2'd1,
      CMD_WR_PLAIN = 2'd2,
      CMD_WR_SHIFT = 2'd3
   } cmd_type;

   localparam int unsigned REL_BIT     = 7;
   localparam logic [6:0]  LSHIFT_CODE = 7'h2A;
   localparam logic [6:0]  RSHIFT_CODE = 7'h36;

   typedef struct packed {
      logic       push;
      logic       pop;
      logic [7:0] char_val;
   } q_op_type;

   typedef struct packed {
      logic [7:0] read_char;
      logic       read_valid;
      logic       char_pushed;
      logic       char_dropped;
      logic       has_input;
   } q_rsp_type;

endpackage

// ----- rtl/kcf_table.sv -----
// ----------------------------------------------------------------------------
// kcf_table
// Character lookup table with per-entry valid bits; unwritten entries read 0.
// ----------------------------------------------------------------------------
module kcf_table #(
   parameter int unsigned MAP_ENTRIES = 128,
   parameter int unsigned MAP_AW      = 7
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [MAP_AW-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [MAP_AW-1:0] rd_addr,
   output logic [7:0]        rd_char
);

   logic [7:0]             mem [MAP_ENTRIES];
   logic [7:0]             rd_data_ff;
   logic [MAP_ENTRIES-1:0] vld_ff;
   logic [MAP_ENTRIES-1:0] vld_in;
   logic                   rd_vld_ff;
   logic                   rd_vld_in;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      vld_in    = vld_ff;
      rd_vld_in = rd_vld_ff;
      if (wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end
      if (rd_en) begin
         rd_vld_in = vld_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         vld_ff    <= vld_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   assign rd_char = rd_vld_ff ? rd_data_ff : 8'h00;

endmodule

// ----- rtl/kcf_queue.sv -----
// ----------------------------------------------------------------------------
// kcf_queue
// Ring character queue holding up to QUEUE_SLOTS-1 entries; registered result.
// ----------------------------------------------------------------------------
module kcf_queue #(
   parameter int unsigned QUEUE_SLOTS = 128,
   parameter int unsigned PTR_W       = 7
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  kcf_pkg::q_op_type op,
   output kcf_pkg::q_rsp_type rsp
);

   logic [7:0]       mem [QUEUE_SLOTS];
   logic [7:0]       rd_data_ff;
   logic [PTR_W-1:0] wp_ff, wp_in, rp_ff, rp_in, wp_nx, rp_nx;
   logic             full, empty;
   logic             do_push, do_pop;
   logic             rvalid_ff, rvalid_in;
   logic             pushed_ff, pushed_in;
   logic             dropped_ff, dropped_in;
   logic             has_ff, has_in;

   assign wp_nx = (wp_ff == PTR_W'(QUEUE_SLOTS - 1)) ? '0 : wp_ff + PTR_W'(1);
   assign rp_nx = (rp_ff == PTR_W'(QUEUE_SLOTS - 1)) ? '0 : rp_ff + PTR_W'(1);
   assign full  = (wp_nx == rp_ff);
   assign empty = (wp_ff == rp_ff);

   assign do_push = en & op.push & ~full;
   assign do_pop  = en & op.pop & ~empty;

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wp_ff] <= op.char_val;
      end
      if (do_pop) begin
         rd_data_ff <= mem[rp_ff];
      end
   end

   always_comb begin
      wp_in      = do_push ? wp_nx : wp_ff;
      rp_in      = do_pop ? rp_nx : rp_ff;
      rvalid_in  = rvalid_ff;
      pushed_in  = pushed_ff;
      dropped_in = dropped_ff;
      has_in     = has_ff;
      if (en) begin
         rvalid_in  = do_pop;
         pushed_in  = do_push;
         dropped_in = op.push & full;
         has_in     = (wp_in != rp_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff      <= '0;
         rp_ff      <= '0;
         rvalid_ff  <= 1'b0;
         pushed_ff  <= 1'b0;
         dropped_ff <= 1'b0;
         has_ff     <= 1'b0;
      end else begin
         wp_ff      <= wp_in;
         rp_ff      <= rp_in;
         rvalid_ff  <= rvalid_in;
         pushed_ff  <= pushed_in;
         dropped_ff <= dropped_in;
         has_ff     <= has_in;
      end
   end

   assign rsp.read_char    = rvalid_ff ? rd_data_ff : 8'h00;
   assign rsp.read_valid   = rvalid_ff;
   assign rsp.char_pushed  = pushed_ff;
   assign rsp.char_dropped = dropped_ff;
   assign rsp.has_input    = has_ff;

endmodule

// ----- rtl/keyboard_scancode_to_char_fifo_unit.sv -----
// ----------------------------------------------------------------------------
// keyboard_scancode_to_char_fifo_unit
// Pipeline: table read at accept into stage 1; the queue updates as stage 1
// moves on, and the result is held in an output register. One word per cycle
// is accepted while the receiver does not stall the output.
// Reset: shift flag, queue pointers and table valid bits clear at once.
// ----------------------------------------------------------------------------
module keyboard_scancode_to_char_fifo_unit #(
   parameter int unsigned QUEUE_SLOTS = 128,
   parameter int unsigned MAP_ENTRIES = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // code_byte[7:0], table_index[14:8], table_char[22:15], zero[23]
   input  logic [23:0] req_tdata,
   // cmd[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // read_char[7:0], read_valid[8], char_pushed[9], char_dropped[10],
   // has_input[11], zero[15:12]
   output logic [15:0] rsp_tdata
);

   localparam int unsigned MAP_AW = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
   localparam int unsigned PTR_W  = $clog2(QUEUE_SLOTS);

   kcf_pkg::cmd_type   cmd;
   logic [7:0]         code;
   logic [6:0]         idx;
   logic [7:0]         tch;
   logic               accept;
   logic               code_in_map, idx_in_map;
   logic               press_shift, rel_shift;
   logic               wr_plain, wr_shift;
   logic               lookup;
   logic               shift_ff, shift_in;
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_lookup_ff;
   logic               s1_pop_ff;
   logic               s1_sel_ff;
   logic               s1_move;
   logic               out_valid_ff, out_valid_in;
   logic [7:0]         plain_char, shifted_char, sel_char;
   kcf_pkg::q_op_type  q_op;
   kcf_pkg::q_rsp_type q_rsp;

   assign cmd  = kcf_pkg::cmd_type'(req_tuser);
   assign code = req_tdata[7:0];
   assign idx  = req_tdata[14:8];
   assign tch  = req_tdata[22:15];

   assign accept      = req_tvalid & req_tready;
   assign code_in_map = ({1'b0, code} < 9'(MAP_ENTRIES));
   assign idx_in_map  = ({1'b0, idx} < 8'(MAP_ENTRIES));
   assign rel_shift   = code[kcf_pkg::REL_BIT] &
                        ((code[6:0] == kcf_pkg::LSHIFT_CODE) ||
                         (code[6:0] == kcf_pkg::RSHIFT_CODE));
   assign press_shift = ~code[kcf_pkg::REL_BIT] &
                        ((code[6:0] == kcf_pkg::LSHIFT_CODE) ||
                         (code[6:0] == kcf_pkg::RSHIFT_CODE));
   assign lookup      = (cmd == kcf_pkg::CMD_SCAN) & ~code[kcf_pkg::REL_BIT] &
                        ~press_shift & code_in_map;
   assign wr_plain    = accept & (cmd == kcf_pkg::CMD_WR_PLAIN) & idx_in_map;
   assign wr_shift    = accept & (cmd == kcf_pkg::CMD_WR_SHIFT) & idx_in_map;

   kcf_table #(
      .MAP_ENTRIES(MAP_ENTRIES),
      .MAP_AW     (MAP_AW)
   ) u_plain (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (wr_plain),
      .wr_addr(idx[MAP_AW-1:0]),
      .wr_data(tch),
      .rd_en  (accept),
      .rd_addr(code[MAP_AW-1:0]),
      .rd_char(plain_char)
   );

   kcf_table #(
      .MAP_ENTRIES(MAP_ENTRIES),
      .MAP_AW     (MAP_AW)
   ) u_shifted (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (wr_shift),
      .wr_addr(idx[MAP_AW-1:0]),
      .wr_data(tch),
      .rd_en  (accept),
      .rd_addr(code[MAP_AW-1:0]),
      .rd_char(shifted_char)
   );

   assign s1_move    = s1_valid_ff & (~out_valid_ff | rsp_tready);
   assign req_tready = ~s1_valid_ff | s1_move;

   always_comb begin
      shift_in     = shift_ff;
      s1_valid_in  = s1_valid_ff;
      out_valid_in = out_valid_ff;
      if (accept && (cmd == kcf_pkg::CMD_SCAN)) begin
         if (rel_shift) begin
            shift_in = 1'b0;
         end else if (press_shift) begin
            shift_in = 1'b1;
         end
      end
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      if (s1_move) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff     <= 1'b0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         shift_ff     <= shift_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_lookup_ff <= lookup;
         s1_pop_ff    <= (cmd == kcf_pkg::CMD_POP);
         s1_sel_ff    <= shift_ff;
      end
   end

   assign sel_char    = s1_sel_ff ? shifted_char : plain_char;
   assign q_op.push     = s1_lookup_ff & (sel_char != 8'h00);
   assign q_op.pop      = s1_pop_ff;
   assign q_op.char_val = sel_char;

   kcf_queue #(
      .QUEUE_SLOTS(QUEUE_SLOTS),
      .PTR_W      (PTR_W)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .en   (s1_move),
      .op   (q_op),
      .rsp  (q_rsp)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'h0, q_rsp.has_input, q_rsp.char_dropped,
                        q_rsp.char_pushed, q_rsp.read_valid, q_rsp.read_char};

`ifndef SYNTHESIS
   a_push_or_drop : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(q_rsp.char_pushed && q_rsp.char_dropped))
      else $error("push and drop flagged together");

   a_pop_excl : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && q_rsp.read_valid |-> !q_rsp.char_pushed && !q_rsp.char_dropped)
      else $error("pop result also flags a push or drop");

   a_push_has : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && q_rsp.char_pushed |-> q_rsp.has_input)
      else $error("queue empty right after a push");

   a_out_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(q_rsp))
      else $error("stalled result changed");
`endif

endmodule

// ----- tb/keyboard_scancode_to_char_fifo_unit_test.sv -----
// ----------------------------------------------------------------------------
// keyboard_scancode_to_char_fifo_unit_test
// Self-checking bench for the set-1 scancode decoder and its character queue.
// A driver streams command words from a pending queue. A monitor predicts each
// accepted word (shift flag, both key maps, a 127-entry character queue) and
// compares every result word field by field. Both sides idle at random. The
// receiver also holds off once for a long stretch so the block backs up.
// ----------------------------------------------------------------------------
module keyboard_scancode_to_char_fifo_unit_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUEUE_SLOTS = 128;
   localparam int MAP_ENTRIES = 128;
   localparam int CHAR_CAP    = QUEUE_SLOTS - 1;
   localparam int MAX_GAP     = 18;
   localparam int HOLD_CYCLES = 400;
   localparam int HOLD_AFTER  = 150;

   typedef struct {
      kcf_pkg::cmd_type cmd;
      logic [7:0]       code_byte;
      logic [6:0]       table_index;
      logic [7:0]       table_char;
   } key_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;

   key_word_type        key_words[$];
   kcf_pkg::q_rsp_type  pending_rsp[$];

   logic       shift_on;
   logic [7:0] plain_map[MAP_ENTRIES];
   logic [7:0] shifted_map[MAP_ENTRIES];
   logic [7:0] char_fifo[$];

   int words_offered = 0;
   int words_taken = 0;
   int rsp_taken = 0;
   int mismatch_count = 0;

   keyboard_scancode_to_char_fifo_unit #(
      .QUEUE_SLOTS(QUEUE_SLOTS),
      .MAP_ENTRIES(MAP_ENTRIES)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   function automatic kcf_pkg::q_rsp_type decode_word(key_word_type w);
      kcf_pkg::q_rsp_type r;
      logic [7:0]         ch;
      logic               is_shift;
      r = '0;
      is_shift = (w.code_byte[6:0] == kcf_pkg::LSHIFT_CODE) ||
                 (w.code_byte[6:0] == kcf_pkg::RSHIFT_CODE);
      case (w.cmd)
         kcf_pkg::CMD_SCAN: begin
            if (w.code_byte[kcf_pkg::REL_BIT]) begin
               if (is_shift) shift_on = 1'b0;
            end else if (is_shift) begin
               shift_on = 1'b1;
            end else begin
               ch = shift_on ? shifted_map[w.code_byte[6:0]] :
                               plain_map[w.code_byte[6:0]];
               if (ch != 8'd0) begin
                  if (char_fifo.size() < CHAR_CAP) begin
                     char_fifo.push_back(ch);
                     r.char_pushed = 1'b1;
                  end else begin
                     r.char_dropped = 1'b1;
                  end
               end
            end
         end
         kcf_pkg::CMD_POP: begin
            if (char_fifo.size() != 0) begin
               r.read_char = char_fifo.pop_front();
               r.read_valid = 1'b1;
            end
         end
         kcf_pkg::CMD_WR_PLAIN: plain_map[w.table_index] = w.table_char;
         kcf_pkg::CMD_WR_SHIFT: shifted_map[w.table_index] = w.table_char;
         default: ;
      endcase
      r.has_input = (char_fifo.size() != 0);
      return r;
   endfunction

   function automatic void add_word(kcf_pkg::cmd_type c, logic [7:0] code,
                                    logic [6:0] idx, logic [7:0] ch);
      key_word_type w;
      w.cmd = c;
      w.code_byte = code;
      w.table_index = idx;
      w.table_char = ch;
      key_words.push_back(w);
   endfunction

   task automatic check_field(input string name, input int unsigned exp_v,
                              input int unsigned act_v);
      if (exp_v != act_v) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
      end
   endtask

   // sender: hold until taken, then idle or present the next word
   int gap_left = 0;
   bit send_quiet = 1'b0;
   always @(negedge clock) begin
      key_word_type w;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!(req_tvalid && words_taken < words_offered)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (key_words.size() != 0) begin
            w = key_words.pop_front();
            req_tdata <= {1'b0, w.table_char, w.table_index, w.code_byte};
            req_tuser <= w.cmd;
            req_tvalid <= 1'b1;
            words_offered++;
            if ($urandom_range(0, 39) == 0) send_quiet = !send_quiet;
            gap_left = send_quiet ? 0 : $urandom_range(0, MAX_GAP);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: stall per result word, one long hold-off midway
   int  stall_left = 0;
   int  rsp_seen = 0;
   bit  recv_quiet = 1'b0;
   bit  hold_done = 1'b0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_taken != rsp_seen) begin
            rsp_seen = rsp_taken;
            if ($urandom_range(0, 39) == 0) recv_quiet = !recv_quiet;
            stall_left = recv_quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (!hold_done && rsp_taken >= HOLD_AFTER) begin
               hold_done = 1'b1;
               stall_left = HOLD_CYCLES;
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // monitor: check result words, then predict accepted command words
   always @(posedge clock) begin
      key_word_type       w;
      kcf_pkg::q_rsp_type e;
      if (reset) begin
         shift_on = 1'b0;
         char_fifo.delete();
         for (int i = 0; i < MAP_ENTRIES; i++) begin
            plain_map[i] = 8'd0;
            shifted_map[i] = 8'd0;
         end
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_taken <= rsp_taken + 1;
            if (pending_rsp.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected result word, expected none actual %h",
                        $time, rsp_tdata);
            end else begin
               e = pending_rsp.pop_front();
               check_field("read_char", 32'(e.read_char), 32'(rsp_tdata[7:0]));
               check_field("read_valid", 32'(e.read_valid), 32'(rsp_tdata[8]));
               check_field("char_pushed", 32'(e.char_pushed), 32'(rsp_tdata[9]));
               check_field("char_dropped", 32'(e.char_dropped), 32'(rsp_tdata[10]));
               check_field("has_input", 32'(e.has_input), 32'(rsp_tdata[11]));
            end
         end
         if (req_tvalid && req_tready) begin
            words_taken <= words_taken + 1;
            w.cmd = kcf_pkg::cmd_type'(req_tuser);
            w.code_byte = req_tdata[7:0];
            w.table_index = req_tdata[14:8];
            w.table_char = req_tdata[22:15];
            pending_rsp.push_back(decode_word(w));
         end
      end
   end

   initial begin
      #(5_000_000);
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      int random_words;
      int fills;
      int seg;
      int r;
      logic [7:0] code;

      // directed: empty pop, zero entry, shift handling, map extremes
      add_word(kcf_pkg::CMD_POP, 8'($urandom), 7'($urandom), 8'($urandom));
      add_word(kcf_pkg::CMD_SCAN, 8'h1E, 7'($urandom), 8'($urandom));
      add_word(kcf_pkg::CMD_WR_PLAIN, 8'($urandom), 7'h00, 8'hFF);
      add_word(kcf_pkg::CMD_WR_PLAIN, 8'($urandom), 7'h7F, 8'h01);
      add_word(kcf_pkg::CMD_WR_PLAIN, 8'($urandom), 7'h10, 8'h71);
      add_word(kcf_pkg::CMD_WR_SHIFT, 8'($urandom), 7'h10, 8'h51);
      add_word(kcf_pkg::CMD_WR_PLAIN, 8'($urandom), 7'h2A, 8'h55);
      add_word(kcf_pkg::CMD_SCAN, 8'h10, 7'($urandom), 8'($urandom));
      add_word(kcf_pkg::CMD_SCAN, 8'h2A, 7'($urandom), 8'($urandom));
      add_word(kcf_pkg::CMD_SCAN, 8'h10, 7'($urandom), 8'($urandom));
      add_word(kcf_pkg::CMD_SCAN, 8'h90, 7'($urandom), 8'($urandom));
      add_word(kcf_pkg::CMD_SCAN, 8'h10, 7'($urandom), 8'($urandom));
      add_word(kcf_pkg::CMD_SCAN, 8'hAA, 7'($urandom), 8'($urandom));
      add_word(kcf_pkg::CMD_SCAN, 8'h36, 7'($urandom), 8'($urandom));
      add_word(kcf_pkg::CMD_SCAN, 8'h2A, 7'($urandom), 8'($urandom));
      add_word(kcf_pkg::CMD_SCAN, 8'hB6, 7'($urandom), 8'($urandom));
      add_word(kcf_pkg::CMD_SCAN, 8'h10, 7'($urandom), 8'($urandom));
      add_word(kcf_pkg::CMD_SCAN, 8'h00, 7'($urandom), 8'($urandom));
      add_word(kcf_pkg::CMD_SCAN, 8'h7F, 7'($urandom), 8'($urandom));
      add_word(kcf_pkg::CMD_SCAN, 8'hFF, 7'($urandom), 8'($urandom));
      add_word(kcf_pkg::CMD_WR_SHIFT, 8'($urandom), 7'h7F, 8'h80);
      for (int i = 0; i < 4; i++)
         add_word(kcf_pkg::CMD_POP, 8'($urandom), 7'($urandom), 8'($urandom));

      // random: load the maps, then typing, map updates and fill/drain runs
      random_words = 0;
      fills = 0;
      for (int i = 0; i < 60; i++) begin
         add_word($urandom_range(0, 1) ? kcf_pkg::CMD_WR_PLAIN : kcf_pkg::CMD_WR_SHIFT,
                  8'($urandom), 7'($urandom_range(0, MAP_ENTRIES - 1)),
                  ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(1, 255)));
         random_words++;
      end
      seg = 0;
      while (random_words < 900) begin
         r = $urandom_range(0, 9);
         if (seg == 2 || seg == 6 || (r == 0 && fills < 3)) begin
            fills++;
            add_word(kcf_pkg::CMD_WR_PLAIN, 8'($urandom), 7'h1E, 8'h61);
            add_word(kcf_pkg::CMD_WR_SHIFT, 8'($urandom), 7'h1E, 8'h41);
            for (int i = 0; i < 135; i++)
               add_word(kcf_pkg::CMD_SCAN, 8'h1E, 7'($urandom), 8'($urandom));
            for (int i = 0; i < 130; i++)
               add_word(kcf_pkg::CMD_POP, 8'($urandom), 7'($urandom), 8'($urandom));
            random_words += 267;
         end else if (r == 1) begin
            for (int i = 0; i < 8; i++) begin
               add_word(kcf_pkg::cmd_type'($urandom_range(2, 3)), 8'($urandom),
                        7'($urandom), 8'($urandom));
               random_words++;
            end
         end else begin
            for (int i = 0; i < 30; i++) begin
               r = $urandom_range(0, 99);
               if (r < 8) begin
                  code = $urandom_range(0, 1) ? 8'h2A : 8'h36;
                  add_word(kcf_pkg::CMD_SCAN, code, 7'($urandom), 8'($urandom));
               end else if (r < 16) begin
                  code = $urandom_range(0, 1) ? 8'hAA : 8'hB6;
                  add_word(kcf_pkg::CMD_SCAN, code, 7'($urandom), 8'($urandom));
               end else if (r < 56) begin
                  add_word(kcf_pkg::CMD_SCAN, 8'($urandom_range(0, 127)), 7'($urandom),
                           8'($urandom));
               end else if (r < 66) begin
                  add_word(kcf_pkg::CMD_SCAN, 8'($urandom_range(0, 255)), 7'($urandom),
                           8'($urandom));
               end else if (r < 96) begin
                  add_word(kcf_pkg::CMD_POP, 8'($urandom), 7'($urandom), 8'($urandom));
               end else begin
                  add_word(kcf_pkg::cmd_type'($urandom_range(2, 3)), 8'($urandom),
                           7'($urandom), 8'($urandom));
               end
               random_words++;
            end
         end
         seg++;
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (key_words.size() != 0 || words_taken != words_offered) @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
